/* hw/rtl/cse_pkg.sv */
// Shared constants, types and saturation helpers for the Chebyshev series evaluator.
// Used by the channel interfaces and by the top level; depends on nothing else.
`default_nettype none

package cse_pkg;

	localparam int COEF_DEPTH = 64;
	localparam int FRAC_BITS  = 16;
	localparam int IDX_W      = $clog2(COEF_DEPTH);
	localparam int DATA_W     = 32;
	localparam int DEG_W      = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int STAT_W     = 2;

	// z carries Z_FRAC+1 fraction bits; its magnitude never exceeds 2^(Z_FRAC+1).
	localparam int Z_FRAC     = 28;
	localparam int Q_W        = Z_FRAC + 2;
	localparam int DIV_STEPS  = Q_W;
	localparam int CNT_W      = $clog2(DIV_STEPS);
	localparam int NUM_W      = DATA_W + 2;
	localparam int DVD_W      = DATA_W + Q_W;

	// Recurrence accumulator and product widths.
	localparam int ACC_W      = 51;
	localparam int MUHI_W     = ACC_W - DATA_W;
	localparam int PLO_W      = Q_W + DATA_W;
	localparam int LOR_W      = PLO_W + 1;
	localparam int PHI_W      = Q_W + MUHI_W;
	localparam int M_W        = ACC_W + 2;
	localparam int SUM_W      = ACC_W + 4;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_EVAL = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OUTSIDE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 2'd2;

	localparam logic signed [DATA_W-1:0] UPPER_RST = (DATA_W)'(1) << FRAC_BITS;
	localparam logic signed [DATA_W-1:0] LOWER_RST = -UPPER_RST;

	typedef enum logic [3:0] {
		S_IDLE,
		S_RDU,
		S_RDV,
		S_CAPV,
		S_DIV,
		S_MLO,
		S_MHI,
		S_RND,
		S_ACC,
		S_PUSH
	} state_t;

	function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [SUM_W-1:0] x);
		logic [SUM_W-ACC_W:0] top;
		top = x[SUM_W-1:ACC_W-1];
		if (&top || ~|top)
			return x[ACC_W-1:0];
		else if (x[SUM_W-1])
			return {1'b1, {(ACC_W-1){1'b0}}};
		else
			return {1'b0, {(ACC_W-1){1'b1}}};
	endfunction

	function automatic logic signed [DATA_W-1:0] sat_out(input logic signed [SUM_W-1:0] x);
		logic [SUM_W-DATA_W:0] top;
		top = x[SUM_W-1:DATA_W-1];
		if (&top || ~|top)
			return x[DATA_W-1:0];
		else if (x[SUM_W-1])
			return {1'b1, {(DATA_W-1){1'b0}}};
		else
			return {1'b0, {(DATA_W-1){1'b1}}};
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/cse_if.sv */
// Valid/ready channel interfaces of the Chebyshev series evaluator:
// item requests, results and configuration writes. Widths come from cse_pkg.
`default_nettype none

interface cse_req_if;
	logic                                valid;
	logic                                ready;
	logic                                kind;
	logic [cse_pkg::IDX_W-1:0]           coef_index;
	logic signed [cse_pkg::DATA_W-1:0]   coef_value;
	logic signed [cse_pkg::DATA_W-1:0]   point;

	modport source(output valid, kind, coef_index, coef_value, point, input ready);
	modport sink(input valid, kind, coef_index, coef_value, point, output ready);
endinterface

interface cse_rsp_if;
	logic                                valid;
	logic                                ready;
	logic signed [cse_pkg::DATA_W-1:0]   value;
	logic [cse_pkg::STAT_W-1:0]          status;

	modport source(output valid, value, status, input ready);
	modport sink(input valid, value, status, output ready);
endinterface

interface cse_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [cse_pkg::CFG_IDX_W-1:0]       index;
	logic [cse_pkg::DATA_W-1:0]          data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/chebyshev_series_evaluator_unit.sv */
// Chebyshev series evaluator (Clenshaw recurrence) over a 64-entry coefficient RAM.
// Evaluate, degree n >= 1: read c[n] and c[n-1], find z with the radix-2 divider, run the
// multiply step (S_MLO, S_MHI, S_RND, S_ACC) per coefficient, then push; no request is
// taken until then. Degree 0 pushes c[0]; an interval or point error pushes a zero.
// A load takes one beat per cycle while idle. Reset restores the bounds to [-1, 1] and
// degree 0; the coefficient RAM is not cleared. Depends on cse_pkg and cse_if.
`default_nettype none

module chebyshev_series_evaluator_unit (
	input  wire logic clk,
	input  wire logic arst_n,
	cse_cfg_if.sink   cfg,
	cse_req_if.sink   req,
	cse_rsp_if.source rsp
);
	import cse_pkg::*;

	state_t state_q, state_d;

	logic signed [DATA_W-1:0] lower_q, upper_q;
	logic [DEG_W-1:0]         degree_q;

	logic [DATA_W-1:0] coef_mem [COEF_DEPTH];
	logic [DATA_W-1:0] rd_q;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              mem_we;

	logic [STAT_W-1:0]        status_d, status_q;
	logic signed [DATA_W-1:0] result_q;
	logic                     push_fire;
	logic                     out_vld_q;
	logic signed [DATA_W-1:0] out_value_q;
	logic [STAT_W-1:0]        out_status_q;

	logic signed [NUM_W-1:0]  num_q;
	logic [DATA_W-1:0]        dvs_q;
	logic                     num_neg_q;
	logic [DATA_W-1:0]        rem_q;
	logic [Q_W-1:0]           low_q;
	logic [Q_W-1:0]           q_q;
	logic [CNT_W-1:0]         cnt_q;

	logic signed [ACC_W-1:0]  u_q, v_q;
	logic [IDX_W-1:0]         k_q;
	logic                     final_q;
	logic                     neg_q;
	logic [MUHI_W-1:0]        muhi_q;
	logic [PLO_W-1:0]         plo_q;
	logic [LOR_W-1:0]         lor_q;
	logic [PHI_W-1:0]         phi_q;
	logic [M_W-1:0]           m_q;

	logic [NUM_W-1:0]         mag;
	logic [DVD_W-1:0]         dvd;
	logic [DATA_W:0]          trial;
	logic                     trial_ge;
	logic [ACC_W-1:0]         mu;
	logic signed [SUM_W-1:0]  sm, acc_sum, coef_diff;
	logic signed [ACC_W-1:0]  rd_ext;

	// Configuration registers; the user must write them only while idle, the block does not enforce it.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q  <= LOWER_RST;
			upper_q  <= UPPER_RST;
			degree_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_LOWER:  lower_q  <= cfg.data;
				CFG_UPPER:  upper_q  <= cfg.data;
				CFG_DEGREE: degree_q <= cfg.data[DEG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (lower_q >= upper_q)
			status_d = STAT_EMPTY;
		else if (req.point < lower_q || req.point > upper_q)
			status_d = STAT_OUTSIDE;
		else
			status_d = STAT_OK;
	end

	// Next state and control.
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = k_q;
		mem_we    = 1'b0;
		push_fire = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					if (req.kind == KIND_LOAD)
						mem_we = 1'b1;
					else if (status_d != STAT_OK)
						state_d = S_PUSH;
					else
						state_d = S_RDU;
				end
			end
			S_RDU: begin
				rd_en   = 1'b1;
				rd_addr = degree_q;
				state_d = S_RDV;
			end
			S_RDV: begin
				rd_en   = 1'b1;
				rd_addr = degree_q - 1'b1;
				state_d = (degree_q == '0) ? S_PUSH : S_CAPV;
			end
			S_CAPV: state_d = S_DIV;
			S_DIV: begin
				if (cnt_q == '0)
					state_d = S_MLO;
			end
			S_MLO: begin
				rd_en   = !final_q;
				state_d = S_MHI;
			end
			S_MHI: state_d = S_RND;
			S_RND: state_d = S_ACC;
			S_ACC: state_d = final_q ? S_PUSH : S_MLO;
			S_PUSH: begin
				push_fire = !out_vld_q || rsp.ready;
				if (push_fire)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	// Coefficient RAM: one write port for loads, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we)
			coef_mem[req.coef_index] <= req.coef_value;
		if (rd_en)
			rd_q <= coef_mem[rd_addr];
	end

	// Datapath arithmetic.
	always_comb begin
		mag      = num_q[NUM_W-1] ? NUM_W'(-num_q) : NUM_W'(num_q);
		dvd      = (DVD_W'(mag[DATA_W-1:0]) << (Z_FRAC + 1)) + DVD_W'(dvs_q >> 1);
		trial    = {rem_q, low_q[Q_W-1]};
		trial_ge = trial >= {1'b0, dvs_q};
		mu       = u_q[ACC_W-1] ? ACC_W'(-u_q) : ACC_W'(u_q);
		rd_ext   = {{(ACC_W-DATA_W){rd_q[DATA_W-1]}}, rd_q};
		sm       = neg_q ? -$signed({2'b00, m_q}) : $signed({2'b00, m_q});
		acc_sum  = sm + {{(SUM_W-ACC_W){v_q[ACC_W-1]}}, v_q};
		coef_diff = {{(SUM_W-DATA_W){rd_q[DATA_W-1]}}, rd_q}
			- {{(SUM_W-ACC_W){u_q[ACC_W-1]}}, u_q};
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				status_q  <= status_d;
				result_q  <= '0;
				num_q     <= (NUM_W'(req.point) <<< 1) - NUM_W'(lower_q) - NUM_W'(upper_q);
				num_neg_q <= 1'b0;
				dvs_q     <= DATA_W'(NUM_W'(upper_q) - NUM_W'(lower_q));
			end
			S_RDU: begin
				num_neg_q <= num_q[NUM_W-1];
				rem_q     <= dvd[DVD_W-1:Q_W];
				low_q     <= dvd[Q_W-1:0];
				cnt_q     <= CNT_W'(DIV_STEPS - 1);
			end
			S_RDV: begin
				u_q <= rd_ext;
				if (degree_q == '0)
					result_q <= rd_q;
			end
			S_CAPV: v_q <= rd_ext;
			S_DIV: begin
				rem_q <= trial_ge ? DATA_W'(trial - {1'b0, dvs_q}) : trial[DATA_W-1:0];
				q_q   <= {q_q[Q_W-2:0], trial_ge};
				low_q <= low_q << 1;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					final_q <= (degree_q == DEG_W'(1));
					k_q     <= IDX_W'(degree_q - DEG_W'(2));
				end
			end
			S_MLO: begin
				plo_q  <= PLO_W'(q_q) * PLO_W'(mu[DATA_W-1:0]);
				muhi_q <= mu[ACC_W-1:DATA_W];
				neg_q  <= num_neg_q ^ u_q[ACC_W-1];
			end
			S_MHI: begin
				phi_q <= PHI_W'(q_q) * PHI_W'(muhi_q);
				// Round to nearest, ties away from zero, on the magnitude.
				lor_q <= final_q ? LOR_W'(plo_q) + (LOR_W'(1) << Z_FRAC)
					: LOR_W'(plo_q) + (LOR_W'(1) << (Z_FRAC - 1));
			end
			S_RND: begin
				if (final_q)
					m_q <= (M_W'(phi_q) << (DATA_W - Z_FRAC - 1)) + M_W'(lor_q >> (Z_FRAC + 1));
				else
					m_q <= (M_W'(phi_q) << (DATA_W - Z_FRAC)) + M_W'(lor_q >> Z_FRAC);
			end
			S_ACC: begin
				if (final_q) begin
					result_q <= sat_out(acc_sum);
				end else begin
					u_q <= sat_acc(acc_sum);
					v_q <= sat_acc(coef_diff);
					if (k_q == '0)
						final_q <= 1'b1;
					else
						k_q <= k_q - 1'b1;
				end
			end
			default: ;
		endcase
	end

	// Output register parts the result channel from the sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (push_fire)
			out_vld_q <= 1'b1;
		else if (rsp.ready)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			out_value_q  <= result_q;
			out_status_q <= status_q;
		end
	end

	assign rsp.valid  = out_vld_q;
	assign rsp.value  = out_value_q;
	assign rsp.status = out_status_q;

	// A load beat never leaves the idle state.
	a_load_stays_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(req.valid && req.ready && req.kind == KIND_LOAD) |=> state_q == S_IDLE)
		else $error("load beat started an evaluation");

	// Any error result carries a zero value.
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != STAT_OK) |-> rsp.value == '0)
		else $error("error result with nonzero value");

	// With the point inside the interval the scaled point stays within 2^(Z_FRAC+1).
	a_quotient_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MLO) |-> q_q <= (Q_W'(1) << (Z_FRAC + 1)))
		else $error("divider quotient out of range");

endmodule

`default_nettype wire

/* bench/testbench.sv */
// Self-checking bench for chebyshev_series_evaluator_unit: coefficient loads, series evaluation,
// interval errors and bound/degree register writes, checked against a local Clenshaw predictor.
// Depends on cse_pkg and the channel interfaces in cse_if.
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cse_pkg::*;

	localparam int CYCLE_LIMIT     = 1_200_000;
	localparam int N_PHASES        = 14;
	localparam int ITEMS_PER_PHASE = 56;
	localparam int HOLD_PHASE      = 4;
	localparam int DRAIN_PHASE     = 6;
	localparam int LONG_HOLD       = 500;
	localparam int DRAIN_IDLE      = 8;
	localparam int DRAIN_END       = 300;
	localparam int N_PROBES        = 35;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
	localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;
	localparam longint ACC_LIM = (longint'(1) << 50) - 1;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic [STAT_W-1:0]        status;
	} series_t;

	typedef enum logic [1:0] {ROW_LOAD, ROW_EVAL, ROW_REG} row_op_e;

	// For ROW_EVAL the data field carries the point; for ROW_REG, sel is the register index.
	typedef struct packed {
		row_op_e           op;
		logic [IDX_W-1:0]  sel;
		logic [DATA_W-1:0] data;
		logic              typed;
		series_t           want;
	} probe_row_t;

	localparam series_t R_NONE    = '0;
	localparam series_t R_OUTSIDE = '{value: '0, status: STAT_OUTSIDE};
	localparam series_t R_EMPTY   = '{value: '0, status: STAT_EMPTY};
	localparam series_t R_MAX     = '{value: S32_MAX, status: STAT_OK};
	localparam series_t R_MIN     = '{value: S32_MIN, status: STAT_OK};

	localparam logic [IDX_W-1:0] R_LO  = IDX_W'(CFG_LOWER);
	localparam logic [IDX_W-1:0] R_HI  = IDX_W'(CFG_UPPER);
	localparam logic [IDX_W-1:0] R_DEG = IDX_W'(CFG_DEGREE);
	localparam logic [IDX_W-1:0] R_NIL = IDX_W'(CFG_UNUSED);

	probe_row_t probes [N_PROBES] = '{
		'{ROW_EVAL, 6'd0, 32'h0002_0000, 1'b1, R_OUTSIDE},
		'{ROW_EVAL, 6'd0, S32_MIN, 1'b1, R_OUTSIDE},
		'{ROW_EVAL, 6'd0, S32_MAX, 1'b1, R_OUTSIDE},
		'{ROW_EVAL, 6'd0, 32'hFFFE_FFFF, 1'b1, R_OUTSIDE},
		'{ROW_LOAD, 6'd0, S32_MAX, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, 32'h0000_0000, 1'b1, R_MAX},
		'{ROW_LOAD, 6'd0, S32_MIN, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, UPPER_RST, 1'b1, R_MIN},
		'{ROW_EVAL, 6'd0, LOWER_RST, 1'b1, R_MIN},
		'{ROW_LOAD, 6'd1, S32_MAX, 1'b0, R_NONE},
		'{ROW_LOAD, 6'd2, S32_MIN, 1'b0, R_NONE},
		'{ROW_LOAD, 6'd63, 32'h0003_0000, 1'b0, R_NONE},
		'{ROW_LOAD, 6'd0, 32'h0000_8000, 1'b0, R_NONE},
		'{ROW_REG, R_DEG, 32'd2, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, 32'h0000_0000, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, UPPER_RST, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, LOWER_RST, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, 32'h0000_4000, 1'b0, R_NONE},
		'{ROW_REG, R_DEG, 32'd1, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, 32'hFFFF_4000, 1'b0, R_NONE},
		'{ROW_REG, R_HI, S32_MAX, 1'b0, R_NONE},
		'{ROW_REG, R_LO, S32_MIN, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, S32_MAX, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, S32_MIN, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, 32'h0000_0000, 1'b0, R_NONE},
		'{ROW_REG, R_LO, S32_MAX, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, S32_MAX, 1'b1, R_EMPTY},
		'{ROW_REG, R_HI, S32_MIN, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, 32'h0000_0000, 1'b1, R_EMPTY},
		'{ROW_REG, R_NIL, 32'hFFFF_FFFF, 1'b0, R_NONE},
		'{ROW_REG, R_LO, 32'h0000_0000, 1'b0, R_NONE},
		'{ROW_REG, R_HI, 32'h0000_0001, 1'b0, R_NONE},
		'{ROW_REG, R_DEG, 32'd2, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, 32'h0000_0001, 1'b0, R_NONE},
		'{ROW_EVAL, 6'd0, 32'h0000_0000, 1'b0, R_NONE}
	};

	logic clk;
	logic arst_n;

	cse_cfg_if cfg_ch();
	cse_req_if req_ch();
	cse_rsp_if rsp_ch();

	chebyshev_series_evaluator_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Predictor state, updated on each accepted beat.
	logic signed [DATA_W-1:0] coef_table [COEF_DEPTH];
	logic signed [DATA_W-1:0] lo_bound;
	logic signed [DATA_W-1:0] hi_bound;
	logic [DEG_W-1:0]         deg_reg;

	series_t series_due [$];

	int  mismatches;
	int  cycle_count;
	int  req_idle_pct;
	int  rsp_idle_pct;
	int  stall_left;
	bit  hold_req;
	bit  calm;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic longint clip(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim - 1)
			return -lim - 1;
		return v;
	endfunction

	// z*u scaled down by 2^sh, rounded half away from zero, split like a 32x64 multiplier.
	function automatic longint scale_product(input longint zq, input longint acc, input int sh);
		longint unsigned mz, mu, lo, hi, m;
		mz = zq < 0 ? -zq : zq;
		mu = acc < 0 ? -acc : acc;
		lo = mz * (mu & 64'hFFFF_FFFF);
		hi = mz * (mu >> 32);
		m = (hi << (32 - sh)) + ((lo + (64'd1 << (sh - 1))) >> sh);
		return ((zq < 0) != (acc < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic series_t clenshaw_eval(input logic signed [DATA_W-1:0] pt);
		series_t res;
		longint a, b, x, num, zq, u, v, w, acc;
		longint unsigned mag, d, q;
		int n, k;
		a = lo_bound;
		b = hi_bound;
		x = pt;
		res.value = '0;
		if (a >= b) begin
			res.status = STAT_EMPTY;
			return res;
		end
		if (x < a || x > b) begin
			res.status = STAT_OUTSIDE;
			return res;
		end
		res.status = STAT_OK;
		n = deg_reg;
		if (n == 0) begin
			acc = coef_table[0];
		end else begin
			num = 2 * x - a - b;
			d = b - a;
			mag = num < 0 ? -num : num;
			q = ((mag << (Z_FRAC + 1)) + d / 2) / d;
			zq = num < 0 ? -longint'(q) : longint'(q);
			u = coef_table[n];
			v = coef_table[n - 1];
			for (k = n - 2; k >= 0; k--) begin
				w = clip(scale_product(zq, u, Z_FRAC) + v, ACC_LIM);
				v = clip(longint'(coef_table[k]) - u, ACC_LIM);
				u = w;
			end
			acc = scale_product(zq, u, Z_FRAC + 1) + v;
		end
		res.value = DATA_W'(clip(acc, longint'(S32_MAX)));
		return res;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] reg_sel,
			input logic [DATA_W-1:0] wdata);
		case (reg_sel)
			CFG_LOWER:  lo_bound = wdata;
			CFG_UPPER:  hi_bound = wdata;
			CFG_DEGREE: deg_reg = wdata[DEG_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_coef();
		case ($urandom_range(0, 7))
			0: return $urandom_range(0, 1) ? S32_MAX : S32_MIN;
			1, 2, 3: return DATA_W'(int'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
			4: return DATA_W'(int'($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
			default: return $urandom();
		endcase
	endfunction

	// Mostly points inside the interval, with its ends, points outside it and raw noise.
	function automatic logic signed [DATA_W-1:0] pick_point();
		longint a, b;
		longint unsigned off;
		a = lo_bound;
		b = hi_bound;
		off = {$urandom(), $urandom()};
		case ($urandom_range(0, 9))
			0: return lo_bound;
			1: return hi_bound;
			2: return $urandom();
			3: if (a > S32_MIN) return DATA_W'(a - 1 - longint'(off % (a - S32_MIN)));
			4: if (b < S32_MAX) return DATA_W'(b + 1 + longint'(off % (S32_MAX - b)));
			default: if (a < b) return DATA_W'(a + longint'(off % (b - a + 1)));
		endcase
		return $urandom();
	endfunction

	function automatic int pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 10;
			default: return 35;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [DATA_W-1:0] want,
			input logic [DATA_W-1:0] got);
		mismatches++;
		$display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
	endtask

	task automatic check_result(input logic signed [DATA_W-1:0] got_val,
			input logic [STAT_W-1:0] got_stat);
		series_t want;
		if (series_due.size() == 0) begin
			report_mismatch("unexpected result", '0, got_val);
			return;
		end
		want = series_due.pop_front();
		if (got_val !== want.value)
			report_mismatch("value", want.value, got_val);
		if (got_stat !== want.status)
			report_mismatch("status", DATA_W'(want.status), DATA_W'(got_stat));
	endtask

	task automatic send_item(input logic op_kind, input logic [IDX_W-1:0] idx,
			input logic signed [DATA_W-1:0] cval, input logic signed [DATA_W-1:0] pt,
			input logic typed = 1'b0, input series_t want = '0);
		req_ch.valid <= 1'b1;
		req_ch.kind <= op_kind;
		req_ch.coef_index <= idx;
		req_ch.coef_value <= cval;
		req_ch.point <= pt;
		do @(posedge clk); while (!req_ch.ready);
		if (op_kind == KIND_LOAD)
			coef_table[idx] = cval;
		else
			series_due.push_back(typed ? want : clenshaw_eval(pt));
	endtask

	task automatic sender_pause();
		if (!calm && $urandom_range(0, 99) < req_idle_pct) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Stop offering beats until every pending result is back, then let loads finish.
	task automatic settle(input int linger);
		req_ch.valid <= 1'b0;
		while (series_due.size() != 0)
			@(posedge clk);
		repeat (linger) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] reg_sel, input logic [DATA_W-1:0] wdata);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= reg_sel;
		cfg_ch.data <= wdata;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(reg_sel, wdata);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic start_phase(input int p);
		logic signed [DATA_W-1:0] lo, hi, t;
		logic [DEG_W-1:0] dg;
		int mode, rot, j;
		mode = (p == 0) ? 2 : ((p < 3 || p == HOLD_PHASE) ? 0 : $urandom_range(0, 9));
		case (mode)
			0, 1: begin
				lo = LOWER_RST;
				hi = UPPER_RST;
			end
			2: begin
				lo = S32_MIN;
				hi = S32_MAX;
			end
			7: begin
				lo = $signed($urandom()) >>> 1;
				hi = lo + $urandom_range(1, 64);
			end
			8: begin
				lo = -int'($urandom_range(0, 32'h0010_0000));
				hi = $urandom_range(1, 32'h0010_0000);
			end
			9: begin
				// Empty or reversed interval: every evaluation must report it.
				hi = $urandom();
				lo = $urandom_range(0, 1) ? hi : $urandom();
				if (lo < hi) begin
					t = lo;
					lo = hi;
					hi = t;
				end
			end
			default: begin
				lo = $urandom();
				hi = $urandom();
				if (lo > hi) begin
					t = lo;
					lo = hi;
					hi = t;
				end
			end
		endcase
		if (p == 0)
			dg = 63;
		else if (p == 1)
			dg = 0;
		else if (p == 2)
			dg = 1;
		else if (p == HOLD_PHASE)
			dg = 2;
		else if (p % 3 == 0)
			dg = DEG_W'($urandom_range(0, 63));
		else
			dg = DEG_W'($urandom_range(1, 10));

		settle(DRAIN_IDLE);
		rot = $urandom_range(0, 2);
		for (j = 0; j < 3; j++) begin
			case ((j + rot) % 3)
				0: write_reg(CFG_LOWER, lo);
				1: write_reg(CFG_UPPER, hi);
				default: write_reg(CFG_DEGREE, {(DATA_W - DEG_W)'($urandom()), dg});
			endcase
		end
		if ($urandom_range(0, 3) == 0)
			write_reg(CFG_UNUSED, $urandom());

		calm = (p >= N_PHASES - 2);
		req_idle_pct = pick_idle_pct();
		rsp_idle_pct = pick_idle_pct();
		if (p == HOLD_PHASE)
			hold_req = 1'b1;
	endtask

	// Result side: checks each beat and drives ready with random stall bursts.
	initial begin
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready)
				check_result(rsp_ch.value, rsp_ch.status);
			if (!arst_n) begin
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else if (hold_req) begin
				// Long hold so the block backs up and stalls its request side.
				hold_req = 1'b0;
				stall_left = LONG_HOLD - 1;
				rsp_ch.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 99) < rsp_idle_pct) begin
				stall_left = $urandom_range(0, 5);
				rsp_ch.ready <= 1'b0;
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count <= CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		int p, i, key;
		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.kind <= KIND_LOAD;
		req_ch.coef_index <= '0;
		req_ch.coef_value <= '0;
		req_ch.point <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= CFG_LOWER;
		cfg_ch.data <= '0;
		lo_bound = LOWER_RST;
		hi_bound = UPPER_RST;
		deg_reg = '0;
		mismatches = 0;
		stall_left = 0;
		hold_req = 1'b0;
		calm = 1'b0;
		req_idle_pct = 20;
		rsp_idle_pct = 20;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (probes[i]) begin
			case (probes[i].op)
				ROW_REG: begin
					settle(DRAIN_IDLE);
					write_reg(probes[i].sel[CFG_IDX_W-1:0], probes[i].data);
				end
				ROW_LOAD: begin
					send_item(KIND_LOAD, probes[i].sel, probes[i].data, $urandom());
					sender_pause();
				end
				default: begin
					send_item(KIND_EVAL, IDX_W'($urandom_range(0, COEF_DEPTH - 1)), $urandom(),
						probes[i].data, probes[i].typed, probes[i].want);
					sender_pause();
				end
			endcase
		end

		// Fill the whole table in a scrambled order so no evaluation reads an unwritten entry.
		key = $urandom_range(0, COEF_DEPTH - 1);
		for (i = 0; i < COEF_DEPTH; i++) begin
			send_item(KIND_LOAD, IDX_W'(i ^ key), pick_coef(), $urandom());
			sender_pause();
		end

		for (p = 0; p < N_PHASES; p++) begin
			start_phase(p);
			for (i = 0; i < ITEMS_PER_PHASE; i++) begin
				if (p == DRAIN_PHASE && i == ITEMS_PER_PHASE / 2)
					settle(0);
				if ($urandom_range(0, 99) < 40)
					send_item(KIND_LOAD, IDX_W'($urandom_range(0, COEF_DEPTH - 1)), pick_coef(),
						$urandom());
				else
					send_item(KIND_EVAL, IDX_W'($urandom_range(0, COEF_DEPTH - 1)), $urandom(),
						pick_point());
				sender_pause();
			end
		end

		settle(DRAIN_END);
		if (mismatches == 0 && series_due.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire

/* files.f */
hw/rtl/cse_pkg.sv
hw/rtl/cse_if.sv
hw/rtl/chebyshev_series_evaluator_unit.sv
bench/testbench.sv
